>>> hw/rtl/kcs_pkg.sv
// keyframe clip sampler package: request kinds, loop modes, divider handshake
// no dependencies
package kcs_pkg;

   localparam logic [1:0] KIND_POSE   = 2'd0;
   localparam logic [1:0] KIND_DUR    = 2'd1;
   localparam logic [1:0] KIND_SAMPLE = 2'd2;

   localparam logic [1:0] LOOP_NONE   = 2'd0;
   localparam logic [1:0] LOOP_MIRROR = 2'd2;

   localparam logic [1:0] CSR_LOOP_MODE   = 2'd0;
   localparam logic [1:0] CSR_FRAME_COUNT = 2'd1;
   localparam logic [1:0] CSR_DOF_COUNT   = 2'd2;

   localparam int PHASE_BITS = 16;
   localparam logic [16:0] PHASE_ONE = 17'h10000;

   typedef struct packed {
      logic        start;
      logic [32:0] init_rem;
      logic [31:0] dividend;
      logic [32:0] divisor;
      logic [5:0]  steps;
   } kcs_div_req_type;

   typedef struct packed {
      logic        done;
      logic [31:0] quot;
      logic [32:0] rem;
   } kcs_div_rsp_type;

endpackage

>>> hw/rtl/keyframe_clip_sampler_top.sv
// keyframe clip sampler top: request decode, sequencer, start-time and pose rams
// depends on kcs_pkg, kcs_ram, kcs_div
//
// channel   dir  handshake             payload
// req_      in   req_tvalid/tready     tuser kind, tdata load and sample fields
// rsp_      out  rsp_tvalid/tready     tdata pose result, tlast last dof
// csr_      in   csr_valid/csr_ready   csr_index, csr_data
//
// loads are written while idle. a sample may run the loop divide, a binary search of the
// start times and the phase divide, then blends each dof in turn; the shared divider and
// the single ram read ports keep these steps in sequence.
// reset is synchronous: state to idle, running time and rsp valid cleared, csr registers to defaults.
// one request is worked at a time; rsp stalls hold the sequencer.
module keyframe_clip_sampler_top #(
   parameter int MAX_FRAMES = 1024,
   parameter int MAX_DOFS   = 64
) (
   input  logic clock,
   input  logic reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [1:0]            req_tuser,   // kind
   // frame_slot, dof_slot, load_value, sample_time, mirror force flag
   input  logic [((($clog2(MAX_FRAMES) + ((MAX_DOFS > 1) ? $clog2(MAX_DOFS) : 1) + 65) + 7)
                  / 8) * 8 - 1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic                  rsp_tlast,
   // dof_out, pose_value, base_frame, blend_phase, cycle_number, mirror_needed, clip_over
   output logic [((($clog2(MAX_FRAMES) + ((MAX_DOFS > 1) ? $clog2(MAX_DOFS) : 1) + 67) + 7)
                  / 8) * 8 - 1:0] rsp_tdata,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [1:0]            csr_index,
   input  logic [15:0]           csr_data
);
   import kcs_pkg::*;

   localparam int FRAME_W  = $clog2(MAX_FRAMES);
   localparam int DOF_W    = (MAX_DOFS > 1) ? $clog2(MAX_DOFS) : 1;
   localparam int FCNT_W   = $clog2(MAX_FRAMES + 1);
   localparam int DCNT_W   = $clog2(MAX_DOFS + 1);
   localparam int PA_W     = $clog2(MAX_FRAMES * MAX_DOFS);
   localparam int IN_BITS  = FRAME_W + DOF_W + 65;
   localparam int IN_TW    = ((IN_BITS + 7) / 8) * 8;
   localparam int OUT_BITS = DOF_W + 32 + FRAME_W + 17 + 16 + 2;
   localparam int OUT_TW   = ((OUT_BITS + 7) / 8) * 8;

   typedef enum logic [12:0] {
      ST_IDLE = 13'b0000000000001,
      ST_DUR  = 13'b0000000000010,
      ST_CDIV = 13'b0000000000100,
      ST_SRCH = 13'b0000000001000,
      ST_SCMP = 13'b0000000010000,
      ST_T0   = 13'b0000000100000,
      ST_T1   = 13'b0000001000000,
      ST_PDIV = 13'b0000010000000,
      ST_EMA  = 13'b0000100000000,
      ST_EMB  = 13'b0001000000000,
      ST_EMM  = 13'b0010000000000,
      ST_EMS  = 13'b0100000000000,
      ST_EMO  = 13'b1000000000000
   } state_type;

   state_type state_ff, state_in;

   logic [1:0]         loop_mode_ff, loop_mode_in;
   logic [10:0]        frame_count_ff, frame_count_in;
   logic [6:0]         dof_count_ff, dof_count_in;
   logic signed [31:0] running_ff, running_in;
   logic signed [31:0] time_ff, time_in;
   logic               force_ff, force_in;
   logic signed [31:0] dur_ff, dur_in;
   logic signed [32:0] r_ff, r_in;
   logic signed [32:0] cycle_ff, cycle_in;
   logic               over_ff, over_in;
   logic [FRAME_W-1:0] idx_ff, idx_in;
   logic [16:0]        phase_ff, phase_in;
   logic [FCNT_W-1:0]  first_ff, first_in;
   logic [FCNT_W-1:0]  count_ff, count_in;
   logic [FCNT_W-1:0]  step_ff, step_in;
   logic signed [31:0] t0_ff, t0_in;
   logic signed [31:0] a_ff, a_in;
   logic signed [49:0] pa_ff, pa_in;
   logic signed [49:0] pb_ff, pb_in;
   logic [DOF_W-1:0]   j_ff, j_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [31:0] pose_ff, pose_in;
   logic               last_ff, last_in;

   // request fields
   logic [FRAME_W-1:0] in_frame;
   logic [DOF_W-1:0]   in_dof;
   logic signed [31:0] in_load;
   logic signed [31:0] in_time;
   logic               in_force;
   logic               req_fire;

   // clamped registers
   logic [FCNT_W-1:0] n_frames;
   logic [DCNT_W-1:0] n_dofs;

   // ram ports
   logic               st_we;
   logic [FRAME_W-1:0] st_waddr, st_raddr;
   logic [31:0]        st_wdata, st_rdata;
   logic signed [31:0] st_rd_s;
   logic               ps_we;
   logic [PA_W-1:0]    ps_waddr, ps_raddr;
   logic [31:0]        ps_rdata;

   kcs_div_req_type div_req;
   kcs_div_rsp_type div_rsp;

   // scratch
   logic signed [32:0] dur_base;
   logic signed [32:0] dur_sum;
   logic [32:0]        t_neg;
   logic signed [33:0] num_c;
   logic signed [32:0] span_c;
   logic [FCNT_W-1:0]  first_m1;
   logic [FCNT_W-1:0]  n_m2;
   logic [FCNT_W-1:0]  sel_idx;
   logic [16:0]        w0;
   logic signed [49:0] blend_sum;
   logic signed [15:0] cyc_sat;
   logic               mirror;

   assign in_frame = req_tdata[FRAME_W-1:0];
   assign in_dof   = req_tdata[FRAME_W +: DOF_W];
   assign in_load  = $signed(req_tdata[FRAME_W + DOF_W +: 32]);
   assign in_time  = $signed(req_tdata[FRAME_W + DOF_W + 32 +: 32]);
   assign in_force = req_tdata[FRAME_W + DOF_W + 64];

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign st_rd_s    = $signed(st_rdata);

   always_comb begin
      if (32'(frame_count_ff) < 32'd2) begin
         n_frames = FCNT_W'(2);
      end else if (32'(frame_count_ff) > 32'(MAX_FRAMES)) begin
         n_frames = FCNT_W'(MAX_FRAMES);
      end else begin
         n_frames = FCNT_W'(frame_count_ff);
      end
      if (dof_count_ff == 7'd0) begin
         n_dofs = DCNT_W'(1);
      end else if (32'(dof_count_ff) > 32'(MAX_DOFS)) begin
         n_dofs = DCNT_W'(MAX_DOFS);
      end else begin
         n_dofs = DCNT_W'(dof_count_ff);
      end
   end

   kcs_ram #(.WIDTH(32), .DEPTH(MAX_FRAMES)) u_start_ram (
      .clock   (clock),
      .wr_en   (st_we),
      .wr_addr (st_waddr),
      .wr_data (st_wdata),
      .rd_addr (st_raddr),
      .rd_data (st_rdata)
   );

   kcs_ram #(.WIDTH(32), .DEPTH(MAX_FRAMES * MAX_DOFS)) u_pose_ram (
      .clock   (clock),
      .wr_en   (ps_we),
      .wr_addr (ps_waddr),
      .wr_data (in_load),
      .rd_addr (ps_raddr),
      .rd_data (ps_rdata)
   );

   kcs_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // load writes
   always_comb begin
      dur_base = (in_frame == '0) ? 33'sd0 : 33'(running_ff);
      dur_sum  = dur_base + 33'(in_load);
      st_we    = req_fire && (req_tuser == KIND_DUR)
                 && (32'(in_frame) < 32'(MAX_FRAMES));
      st_waddr = in_frame;
      st_wdata = dur_base[31:0];
      ps_we    = req_fire && (req_tuser == KIND_POSE)
                 && (32'(in_frame) < 32'(MAX_FRAMES)) && (32'(in_dof) < 32'(MAX_DOFS));
      ps_waddr = PA_W'(in_frame) * PA_W'(MAX_DOFS) + PA_W'(in_dof);
   end

   always_comb begin
      state_in       = state_ff;
      loop_mode_in   = loop_mode_ff;
      frame_count_in = frame_count_ff;
      dof_count_in   = dof_count_ff;
      running_in     = running_ff;
      time_in        = time_ff;
      force_in       = force_ff;
      dur_in         = dur_ff;
      r_in           = r_ff;
      cycle_in       = cycle_ff;
      over_in        = over_ff;
      idx_in         = idx_ff;
      phase_in       = phase_ff;
      first_in       = first_ff;
      count_in       = count_ff;
      step_in        = step_ff;
      t0_in          = t0_ff;
      a_in           = a_ff;
      pa_in          = pa_ff;
      pb_in          = pb_ff;
      j_in           = j_ff;
      rsp_valid_in   = rsp_valid_ff;
      pose_in        = pose_ff;
      last_in        = last_ff;
      st_raddr       = FRAME_W'(n_frames - FCNT_W'(1));
      ps_raddr       = PA_W'(idx_ff) * PA_W'(MAX_DOFS) + PA_W'(j_ff);
      div_req        = '0;
      t_neg          = -{time_ff[31], time_ff};
      num_c          = 34'(r_ff) - 34'(t0_ff);
      span_c         = 33'(st_rd_s) - 33'(t0_ff);
      first_m1       = first_ff - FCNT_W'(1);
      n_m2           = n_frames - FCNT_W'(2);
      sel_idx        = '0;
      w0             = PHASE_ONE - phase_ff;
      blend_sum      = pa_ff + pb_ff + 50'sd32768;

      if (csr_valid) begin
         case (csr_index)
            CSR_LOOP_MODE:   loop_mode_in   = csr_data[1:0];
            CSR_FRAME_COUNT: frame_count_in = csr_data[10:0];
            CSR_DOF_COUNT:   dof_count_in   = csr_data[6:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (st_we) begin
               if (dur_sum > 33'sd2147483647) begin
                  running_in = 32'sh7fffffff;
               end else if (dur_sum < -33'sd2147483648) begin
                  running_in = 32'sh80000000;
               end else begin
                  running_in = dur_sum[31:0];
               end
            end
            if (req_fire && (req_tuser == KIND_SAMPLE)) begin
               time_in  = in_time;
               force_in = in_force;
               j_in     = '0;
               state_in = ST_DUR;
            end
         end
         ST_DUR: begin
            dur_in   = st_rd_s;
            r_in     = 33'(time_ff);
            cycle_in = '0;
            idx_in   = '0;
            phase_in = '0;
            first_in = '0;
            count_in = n_frames;
            over_in  = (loop_mode_ff == LOOP_NONE) && (time_ff >= st_rd_s);
            if (loop_mode_ff == LOOP_NONE) begin
               if (time_ff <= 32'sd0) begin
                  state_in = ST_EMA;
               end else if (time_ff >= st_rd_s) begin
                  idx_in   = FRAME_W'(n_m2);
                  phase_in = PHASE_ONE;
                  cycle_in = 33'sd1;
                  state_in = ST_EMA;
               end else begin
                  state_in = ST_SRCH;
               end
            end else if (st_rd_s <= 32'sd0) begin
               state_in = ST_EMA;
            end else begin
               div_req.start    = 1'b1;
               div_req.init_rem = '0;
               div_req.dividend = time_ff[31] ? t_neg[31:0] : time_ff;
               div_req.divisor  = {1'b0, st_rdata};
               div_req.steps    = 6'd32;
               state_in         = ST_CDIV;
            end
         end
         ST_CDIV: begin
            if (div_rsp.done) begin
               if (!time_ff[31]) begin
                  cycle_in = $signed({1'b0, div_rsp.quot});
                  r_in     = $signed(div_rsp.rem);
               end else if (div_rsp.rem == '0) begin
                  cycle_in = -$signed({1'b0, div_rsp.quot});
                  r_in     = '0;
               end else begin
                  cycle_in = -$signed({1'b0, div_rsp.quot}) - 33'sd1;
                  r_in     = 33'(dur_ff) - $signed(div_rsp.rem);
               end
               state_in = ST_SRCH;
            end
         end
         ST_SRCH: begin
            if (count_ff == '0) begin
               // base is one below the upper bound, held inside the clip
               if (first_ff == '0) begin
                  sel_idx = '0;
               end else if (first_m1 > n_m2) begin
                  sel_idx = n_m2;
               end else begin
                  sel_idx = first_m1;
               end
               idx_in   = FRAME_W'(sel_idx);
               st_raddr = FRAME_W'(sel_idx);
               state_in = ST_T0;
            end else begin
               step_in  = count_ff >> 1;
               st_raddr = FRAME_W'(first_ff + (count_ff >> 1));
               state_in = ST_SCMP;
            end
         end
         ST_SCMP: begin
            if (!(r_ff < 33'(st_rd_s))) begin
               first_in = first_ff + step_ff + FCNT_W'(1);
               count_in = count_ff - step_ff - FCNT_W'(1);
            end else begin
               count_in = step_ff;
            end
            state_in = ST_SRCH;
         end
         ST_T0: begin
            t0_in    = st_rd_s;
            st_raddr = idx_ff + FRAME_W'(1);
            state_in = ST_T1;
         end
         ST_T1: begin
            state_in = ST_EMA;
            if (span_c <= 33'sd0) begin
               phase_in = (num_c > 34'sd0) ? PHASE_ONE : 17'd0;
            end else if (num_c <= 34'sd0) begin
               phase_in = '0;
            end else if (num_c >= 34'(span_c)) begin
               phase_in = PHASE_ONE;
            end else begin
               // quotient of num << 16 by span, known below one
               div_req.start    = 1'b1;
               div_req.init_rem = num_c[32:0];
               div_req.dividend = '0;
               div_req.divisor  = span_c;
               div_req.steps    = 6'(PHASE_BITS);
               state_in         = ST_PDIV;
            end
         end
         ST_PDIV: begin
            if (div_rsp.done) begin
               phase_in = {1'b0, div_rsp.quot[15:0]};
               state_in = ST_EMA;
            end
         end
         ST_EMA: begin
            state_in = ST_EMB;
         end
         ST_EMB: begin
            a_in     = $signed(ps_rdata);
            ps_raddr = PA_W'(idx_ff + FRAME_W'(1)) * PA_W'(MAX_DOFS) + PA_W'(j_ff);
            state_in = ST_EMM;
         end
         ST_EMM: begin
            pa_in    = a_ff * $signed({1'b0, w0});
            pb_in    = $signed(ps_rdata) * $signed({1'b0, phase_ff});
            state_in = ST_EMS;
         end
         ST_EMS: begin
            pose_in      = blend_sum[47:16];
            last_in      = (DCNT_W'(j_ff) + DCNT_W'(1)) == n_dofs;
            rsp_valid_in = 1'b1;
            state_in     = ST_EMO;
         end
         ST_EMO: begin
            if (rsp_tready) begin
               rsp_valid_in = 1'b0;
               if (last_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  j_in     = j_ff + DOF_W'(1);
                  state_in = ST_EMA;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         loop_mode_ff   <= LOOP_NONE;
         frame_count_ff <= 11'd2;
         dof_count_ff   <= 7'd1;
         running_ff     <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         loop_mode_ff   <= loop_mode_in;
         frame_count_ff <= frame_count_in;
         dof_count_ff   <= dof_count_in;
         running_ff     <= running_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      time_ff  <= time_in;
      force_ff <= force_in;
      dur_ff   <= dur_in;
      r_ff     <= r_in;
      cycle_ff <= cycle_in;
      over_ff  <= over_in;
      idx_ff   <= idx_in;
      phase_ff <= phase_in;
      first_ff <= first_in;
      count_ff <= count_in;
      step_ff  <= step_in;
      t0_ff    <= t0_in;
      a_ff     <= a_in;
      pa_ff    <= pa_in;
      pb_ff    <= pb_in;
      j_ff     <= j_in;
      pose_ff  <= pose_in;
      last_ff  <= last_in;
   end

   always_comb begin
      if (cycle_ff > 33'sd32767) begin
         cyc_sat = 16'sh7fff;
      end else if (cycle_ff < -33'sd32768) begin
         cyc_sat = 16'sh8000;
      end else begin
         cyc_sat = cycle_ff[15:0];
      end
      mirror = force_ff || ((loop_mode_ff == LOOP_MIRROR) && cycle_ff[0]);
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = last_ff;
   assign rsp_tdata  = OUT_TW'({over_ff, mirror, cyc_sat, phase_ff, idx_ff, pose_ff, j_ff});
endmodule

>>> hw/rtl/kcs_ram.sv
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module kcs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

>>> hw/rtl/kcs_div.sv
// restoring divider, one quotient bit per cycle, shared by cycle and phase math
// depends on kcs_pkg
module kcs_div (
   input  logic                     clock,
   input  logic                     reset,
   input  kcs_pkg::kcs_div_req_type div_req,
   output kcs_pkg::kcs_div_rsp_type div_rsp
);
   import kcs_pkg::*;

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [32:0] rem_ff, rem_in;
   logic [31:0] dvd_ff, dvd_in;
   logic [32:0] dsr_ff, dsr_in;
   logic [31:0] quot_ff, quot_in;
   logic [33:0] shifted;
   logic [33:0] diff;
   logic        fits;

   always_comb begin
      shifted = {rem_ff, dvd_ff[31]};
      diff    = shifted - {1'b0, dsr_ff};
      fits    = shifted >= {1'b0, dsr_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      dsr_in  = dsr_ff;
      quot_in = quot_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = div_req.steps;
         rem_in  = div_req.init_rem;
         dvd_in  = div_req.dividend;
         dsr_in  = div_req.divisor;
         quot_in = '0;
      end else if (busy_ff) begin
         rem_in  = fits ? diff[32:0] : shifted[32:0];
         quot_in = {quot_ff[30:0], fits};
         dvd_in  = {dvd_ff[30:0], 1'b0};
         cnt_in  = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      rem_ff  <= rem_in;
      dvd_ff  <= dvd_in;
      dsr_ff  <= dsr_in;
      quot_ff <= quot_in;
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quot = quot_ff;
   assign div_rsp.rem  = rem_ff;
endmodule
